FILE: src/stsum_pkg.sv
// ----------------------------------------------------------------------------
// Segment tree range sum: shared package
// Field widths, input mode codes, sequencer states and the status record
// passed from the tree walker to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package stsum_pkg;

    localparam int SUM_W       = 42;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int RESET_COUNT = 1024;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_DESC,
        ST_UPD_SUM,
        ST_QRY_WALK,
        ST_QRY_DRAIN,
        ST_QRY_DONE
    } state_t;

    typedef struct packed {
        logic ready;
        logic done;
        sum_t sum;
    } walk_status_t;

endpackage

`default_nettype wire

FILE: src/segment_tree_range_sum_unit.sv
// ----------------------------------------------------------------------------
// Segment tree range sum unit
// Sum tree over up to MAX_ELEMENTS signed 32-bit values with point updates
// and inclusive range sum queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready). s_mode selects a point
//   update (s_position, s_value) or a range query (s_range_low, s_range_high).
//   Only a query produces a response, a 42-bit wrapped sum on the m_ channel.
//   The cfg channel writes element_count; write it only while the unit is idle.
//   One request is processed at a time. An update walks down to the leaf
//   one level at a time (the tree has 11 levels for 1024 elements), then
//   walks back up with one read-sum-write step per level, through the
//   single read port of the node store. A query spends one step on each
//   node it visits, from the root alone up to four nodes per level, then
//   folds in the last node read and parks the sum.
//   After reset all 4*MAX_ELEMENTS node store entries (4096 by default)
//   are cleared one entry per cycle; s_ready stays low meanwhile, while
//   configuration writes are taken as usual.
//   A finished query sum sits in an output register; while m_ready is low the
//   unit keeps accepting and running updates, and stalls only when a second
//   query result would have to be delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Request channel.
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_mode,
    input  wire logic [stsum_pkg::IDX_W-1:0]           s_position,
    input  wire logic signed [stsum_pkg::VALUE_W-1:0]  s_value,
    input  wire logic [stsum_pkg::IDX_W-1:0]           s_range_low,
    input  wire logic [stsum_pkg::IDX_W-1:0]           s_range_high,
    // Response channel.
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [stsum_pkg::SUM_W-1:0]         m_range_sum,
    // Configuration write channel (element_count).
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [stsum_pkg::CNT_W-1:0]           cfg_wdata
);

    localparam int NODE_COUNT = 4 * MAX_ELEMENTS;
    localparam int NW = $clog2(NODE_COUNT);
    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int RESET_EFF = (stsum_pkg::RESET_COUNT > MAX_ELEMENTS) ?
                               MAX_ELEMENTS : stsum_pkg::RESET_COUNT;
    localparam logic [IW-1:0] LAST_RESET = IW'(RESET_EFF - 1);

    // The tree is kept as the index of its last element: the written count
    // is clamped to 1..MAX_ELEMENTS once, when it is written.
    logic [IW-1:0] last_reg, last_next;
    logic [31:0]   cnt_eff;

    logic            out_valid_reg, out_valid_next;
    stsum_pkg::sum_t out_sum_reg, out_sum_next;

    stsum_pkg::walk_status_t status;
    logic            res_ready;
    logic            mem_we;
    logic [NW-1:0]   mem_waddr;
    stsum_pkg::sum_t mem_wdata;
    logic            mem_re;
    logic [NW-1:0]   mem_raddr;
    stsum_pkg::sum_t mem_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (cfg_wdata == '0) begin
            cnt_eff = 32'd1;
        end else if (32'(cfg_wdata) > 32'(MAX_ELEMENTS)) begin
            cnt_eff = 32'(MAX_ELEMENTS);
        end else begin
            cnt_eff = 32'(cfg_wdata);
        end
        last_next = (cfg_valid && cfg_ready) ? IW'(cnt_eff - 32'd1) : last_reg;
    end

    // The output register frees the walker as soon as a result is parked.
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        if (status.done && res_ready) begin
            out_valid_next = 1'b1;
            out_sum_next   = status.sum;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg      <= LAST_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_sum_reg <= out_sum_next;
    end

    assign s_ready     = status.ready;
    assign m_valid     = out_valid_reg;
    assign m_range_sum = out_sum_reg;

    stsum_walker #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_valid && s_ready),
        .mode       (s_mode),
        .position   (s_position),
        .value      (s_value),
        .range_low  (s_range_low),
        .range_high (s_range_high),
        .last_index (last_reg),
        .res_ready  (res_ready),
        .status     (status),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    stsum_node_ram #(
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: src/stsum_node_ram.sv
// ----------------------------------------------------------------------------
// Segment tree node store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_node_ram #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire stsum_pkg::sum_t       wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output stsum_pkg::sum_t            rdata
);

    stsum_pkg::sum_t mem [DEPTH];
    stsum_pkg::sum_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/stsum_walker.sv
// ----------------------------------------------------------------------------
// Segment tree walker
// Sequencer that clears the node store, runs point updates (descend to the
// leaf, then re-sum ancestors) and range queries (depth-first walk with a
// small stack of pending right children).
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_walker #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int NODE_COUNT = 4 * MAX_ELEMENTS,
    localparam int NW = $clog2(NODE_COUNT),
    localparam int IW = $clog2(MAX_ELEMENTS)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic                         mode,
    input  wire logic [stsum_pkg::IDX_W-1:0]  position,
    input  wire logic signed [stsum_pkg::VALUE_W-1:0] value,
    input  wire logic [stsum_pkg::IDX_W-1:0]  range_low,
    input  wire logic [stsum_pkg::IDX_W-1:0]  range_high,
    input  wire logic [IW-1:0]                last_index,
    input  wire logic                         res_ready,
    output stsum_pkg::walk_status_t           status,
    output logic                              mem_we,
    output logic [NW-1:0]                     mem_waddr,
    output stsum_pkg::sum_t                   mem_wdata,
    output logic                              mem_re,
    output logic [NW-1:0]                     mem_raddr,
    input  wire stsum_pkg::sum_t              mem_rdata
);

    localparam int SDEPTH = IW;
    localparam int SIW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int SPW = $clog2(SDEPTH + 1);

    function automatic logic [NW-1:0] sib_of(input logic [NW-1:0] n);
        return n[0] ? (n + NW'(1)) : (n - NW'(1));
    endfunction

    function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] n);
        logic [NW-1:0] d;
        d = n - NW'(1);
        return d >> 1;
    endfunction

    stsum_pkg::state_t state_reg, state_next;
    logic [NW-1:0]  node_reg, node_next;
    logic [IW-1:0]  start_reg, start_next;
    logic [IW-1:0]  end_reg, end_next;
    logic [IW-1:0]  pos_reg, pos_next;
    logic [stsum_pkg::IDX_W-1:0] lo_reg, lo_next;
    logic [stsum_pkg::IDX_W-1:0] hi_reg, hi_next;
    stsum_pkg::sum_t cur_reg, cur_next;
    stsum_pkg::sum_t acc_reg, acc_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic           rd_pend_reg, rd_pend_next;
    logic [NW-1:0]  clr_reg, clr_next;

    logic [NW-1:0]  stk_node_reg [SDEPTH];
    logic [IW-1:0]  stk_start_reg [SDEPTH];
    logic [IW-1:0]  stk_end_reg [SDEPTH];

    logic [IW:0]    mid_wide;
    logic [IW-1:0]  mid;
    logic [IW-1:0]  mid_inc;
    logic [NW:0]    node_dbl;
    logic [NW-1:0]  left_node;
    logic [NW-1:0]  right_node;
    logic [NW-1:0]  up_node;
    logic [SPW-1:0] sp_top;
    logic           q_disj;
    logic           q_cov;
    logic           push;
    stsum_pkg::sum_t leaf_in;
    stsum_pkg::sum_t up_sum;

    assign mid_wide   = {1'b0, start_reg} + {1'b0, end_reg};
    assign mid        = mid_wide[IW:1];
    assign mid_inc    = mid + IW'(1);
    assign node_dbl   = {node_reg, 1'b0};
    assign left_node  = NW'(node_dbl + (NW+1)'(1));
    assign right_node = NW'(node_dbl + (NW+1)'(2));
    assign up_node    = parent_of(node_reg);
    assign sp_top     = sp_reg - SPW'(1);
    assign leaf_in    = {{(stsum_pkg::SUM_W - stsum_pkg::VALUE_W){value[stsum_pkg::VALUE_W-1]}},
                         value};
    assign up_sum     = cur_reg + mem_rdata;

    assign q_disj = (32'(hi_reg) < 32'(start_reg)) || (32'(end_reg) < 32'(lo_reg));
    assign q_cov  = (32'(lo_reg) <= 32'(start_reg)) && (32'(end_reg) <= 32'(hi_reg));

    // Next state and datapath.
    always_comb begin
        state_next = state_reg;
        node_next  = node_reg;
        start_next = start_reg;
        end_next   = end_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        cur_next   = cur_reg;
        acc_next   = rd_pend_reg ? (acc_reg + mem_rdata) : acc_reg;
        sp_next    = sp_reg;
        clr_next   = clr_reg;
        case (state_reg)
            stsum_pkg::ST_CLEAR: begin
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(NODE_COUNT - 1)) begin
                    state_next = stsum_pkg::ST_IDLE;
                end
            end
            stsum_pkg::ST_IDLE: begin
                if (start) begin
                    node_next  = '0;
                    start_next = '0;
                    end_next   = last_index;
                    pos_next   = IW'(position);
                    lo_next    = range_low;
                    hi_next    = range_high;
                    cur_next   = leaf_in;
                    acc_next   = '0;
                    sp_next    = '0;
                    if (mode == stsum_pkg::MODE_QUERY) begin
                        state_next = stsum_pkg::ST_QRY_WALK;
                    end else if (32'(position) <= 32'(last_index)) begin
                        state_next = stsum_pkg::ST_UPD_DESC;
                    end
                end
            end
            stsum_pkg::ST_UPD_DESC: begin
                if (start_reg == end_reg) begin
                    if (node_reg == '0) begin
                        state_next = stsum_pkg::ST_IDLE;
                    end else begin
                        state_next = stsum_pkg::ST_UPD_SUM;
                    end
                end else if (pos_reg <= mid) begin
                    node_next = left_node;
                    end_next  = mid;
                end else begin
                    node_next  = right_node;
                    start_next = mid_inc;
                end
            end
            stsum_pkg::ST_UPD_SUM: begin
                cur_next  = up_sum;
                node_next = up_node;
                if (up_node == '0) begin
                    state_next = stsum_pkg::ST_IDLE;
                end
            end
            stsum_pkg::ST_QRY_WALK: begin
                if (q_disj || q_cov) begin
                    if (sp_reg == '0) begin
                        state_next = stsum_pkg::ST_QRY_DRAIN;
                    end else begin
                        node_next  = stk_node_reg[sp_top[SIW-1:0]];
                        start_next = stk_start_reg[sp_top[SIW-1:0]];
                        end_next   = stk_end_reg[sp_top[SIW-1:0]];
                        sp_next    = sp_top;
                    end
                end else begin
                    node_next = left_node;
                    end_next  = mid;
                    sp_next   = sp_reg + SPW'(1);
                end
            end
            stsum_pkg::ST_QRY_DRAIN: begin
                state_next = stsum_pkg::ST_QRY_DONE;
            end
            stsum_pkg::ST_QRY_DONE: begin
                if (res_ready) begin
                    state_next = stsum_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stsum_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port and status outputs.
    always_comb begin
        mem_we        = 1'b0;
        mem_waddr     = node_reg;
        mem_wdata     = cur_reg;
        mem_re        = 1'b0;
        mem_raddr     = sib_of(node_reg);
        push          = 1'b0;
        rd_pend_next  = 1'b0;
        status.ready  = 1'b0;
        status.done   = 1'b0;
        status.sum    = acc_reg;
        case (state_reg)
            stsum_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            stsum_pkg::ST_IDLE: begin
                status.ready = 1'b1;
            end
            stsum_pkg::ST_UPD_DESC: begin
                if (start_reg == end_reg) begin
                    mem_we = 1'b1;
                    mem_re = (node_reg != '0);
                end
            end
            stsum_pkg::ST_UPD_SUM: begin
                mem_we    = 1'b1;
                mem_waddr = up_node;
                mem_wdata = up_sum;
                mem_re    = (up_node != '0);
                mem_raddr = sib_of(up_node);
            end
            stsum_pkg::ST_QRY_WALK: begin
                mem_raddr    = node_reg;
                mem_re       = q_cov && !q_disj;
                rd_pend_next = q_cov && !q_disj;
                push         = !(q_disj || q_cov);
            end
            stsum_pkg::ST_QRY_DRAIN: begin
            end
            stsum_pkg::ST_QRY_DONE: begin
                status.done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stsum_pkg::ST_CLEAR;
            clr_reg     <= '0;
            sp_reg      <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg  <= node_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        cur_reg   <= cur_next;
        acc_reg   <= acc_next;
        if (push) begin
            stk_node_reg[sp_reg[SIW-1:0]]  <= right_node;
            stk_start_reg[sp_reg[SIW-1:0]] <= mid_inc;
            stk_end_reg[sp_reg[SIW-1:0]]   <= end_reg;
        end
    end

    // A query never modifies the tree.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stsum_pkg::ST_QRY_WALK || state_reg == stsum_pkg::ST_QRY_DRAIN ||
         state_reg == stsum_pkg::ST_QRY_DONE) |-> !mem_we)
        else $error("tree written during a query");

    // The pending-child stack never overflows.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stsum_pkg::ST_QRY_WALK && push) |-> (sp_reg < SPW'(SDEPTH)))
        else $error("query stack overflow");

    // Each ascent step writes the parent of the node written just before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stsum_pkg::ST_UPD_SUM) |->
            (mem_we && $past(mem_we) && mem_waddr == parent_of($past(mem_waddr))))
        else $error("ascent skipped a tree level");

    // The last node read is folded in before the sum is offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stsum_pkg::ST_QRY_DONE) |-> !rd_pend_reg)
        else $error("query finished with a read outstanding");

endmodule

`default_nettype wire
